@@ hw/rtl/cqsi_pkg.sv @@
package cqsi_pkg;

  // Ring size; the queue holds at most DEPTH-1 entries.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 4;
  localparam int VAL_W = 32;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_PRIO = 2'd1,
    CMD_DEQ  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  // Operation broadcast to every cell; at most one bit is set.
  typedef struct packed {
    logic enq;
    logic prio;
    logic deq;
  } cell_op_t;

endpackage

@@ hw/rtl/circular_queue_with_sorted_insert.sv @@
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_cmd, in_value
// out_     output     out_valid/out_stall out_accepted, out_popped_value,
//                                         out_entry_count, out_is_empty,
//                                         out_is_full
//
// For each item the row of cells compares all entries with the new value
// and shifts in parallel, and the result is registered at once.
// One item per cycle is sustained while the result side takes every item.
// rst_n is synchronous and active low; it empties the queue and clears the
// result valid flag. in_stall rises only while a result waits under out_stall.
module circular_queue_with_sorted_insert (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic signed [cqsi_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic signed [cqsi_pkg::VAL_W-1:0] out_popped_value,
  output logic [cqsi_pkg::CNT_W-1:0]        out_entry_count,
  output logic                              out_is_empty,
  output logic                              out_is_full
);

  localparam int D = cqsi_pkg::DEPTH;

  logic [cqsi_pkg::IDX_W-1:0]        count_r;
  logic [cqsi_pkg::IDX_W-1:0]        count_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic                              out_accepted_r;
  logic signed [cqsi_pkg::VAL_W-1:0] out_popped_r;
  logic [cqsi_pkg::CNT_W-1:0]        out_count_r;
  logic                              out_empty_r;
  logic                              out_full_r;

  logic                              accept;
  logic                              full;
  logic                              empty;
  logic                              done;
  cqsi_pkg::cmd_t                    cmd;
  cqsi_pkg::cell_op_t                op;

  logic signed [cqsi_pkg::VAL_W-1:0] cell_val [D];
  logic                              s_chain  [D+1];
  logic                              occ      [D];
  logic                              at_tail  [D];

  assign cmd      = cqsi_pkg::cmd_t'(in_cmd);
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign full     = (count_r == cqsi_pkg::IDX_W'(D - 1));
  assign empty    = (count_r == '0);

  // Decode the command into the operation every cell sees.
  always_comb begin
    op   = '0;
    done = 1'b0;
    if (accept) begin
      case (cmd)
        cqsi_pkg::CMD_ENQ: begin
          op.enq = ~full;
          done   = ~full;
        end
        cqsi_pkg::CMD_PRIO: begin
          op.prio = ~full;
          done    = ~full;
        end
        cqsi_pkg::CMD_DEQ: begin
          op.deq = ~empty;
          done   = ~empty;
        end
        default: begin
          done = 1'b0;
        end
      endcase
    end
  end

  // Entry count follows the operation.
  always_comb begin
    count_nxt = count_r;
    if (op.enq || op.prio) begin
      count_nxt = count_r + 1'b1;
    end else if (op.deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Row of cells; cell 0 holds the head. The suffix flag ripples from the
  // tail end toward the head.
  assign s_chain[D] = 1'b1;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                              s_left;
    logic signed [cqsi_pkg::VAL_W-1:0] left_val;
    logic signed [cqsi_pkg::VAL_W-1:0] right_val;

    assign occ[i]     = (cqsi_pkg::IDX_W'(i) < count_r);
    assign at_tail[i] = (cqsi_pkg::IDX_W'(i) == count_r);

    if (i == 0) begin : g_first
      assign s_left   = 1'b0;
      assign left_val = '0;
    end else begin : g_mid
      assign s_left   = s_chain[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == D - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    cqsi_cell u_cell (
      .clk       (clk),
      .op        (op),
      .new_val   (in_value),
      .occ       (occ[i]),
      .at_tail   (at_tail[i]),
      .s_in      (s_chain[i+1]),
      .s_left    (s_left),
      .left_val  (left_val),
      .right_val (right_val),
      .value     (cell_val[i]),
      .s_out     (s_chain[i])
    );
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, captured when the item is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_accepted_r <= done;
      out_popped_r   <= op.deq ? cell_val[0] : '0;
      out_count_r    <= cqsi_pkg::CNT_W'(count_nxt);
      out_empty_r    <= (count_nxt == '0);
      out_full_r     <= (count_nxt == cqsi_pkg::IDX_W'(D - 1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_popped_value = out_popped_r;
  assign out_entry_count  = out_count_r;
  assign out_is_empty     = out_empty_r;
  assign out_is_full      = out_full_r;

endmodule

@@ hw/rtl/cqsi_cell.sv @@
module cqsi_cell (
  input  logic                              clk,
  input  cqsi_pkg::cell_op_t                op,
  input  logic signed [cqsi_pkg::VAL_W-1:0] new_val,
  input  logic                              occ,
  input  logic                              at_tail,
  input  logic                              s_in,
  input  logic                              s_left,
  input  logic signed [cqsi_pkg::VAL_W-1:0] left_val,
  input  logic signed [cqsi_pkg::VAL_W-1:0] right_val,
  output logic signed [cqsi_pkg::VAL_W-1:0] value,
  output logic                              s_out
);

  logic signed [cqsi_pkg::VAL_W-1:0] value_r;
  logic signed [cqsi_pkg::VAL_W-1:0] value_nxt;
  logic                              gt;

  // Suffix flag: every occupied entry from this cell toward the tail is
  // greater than the new value.
  assign gt    = value_r > new_val;
  assign s_out = s_in & (~occ | gt);
  assign value = value_r;

  // Entry update: append, sorted insert with shift toward the tail, or
  // shift toward the head on a pop.
  always_comb begin
    value_nxt = value_r;
    if (op.enq && at_tail) begin
      value_nxt = new_val;
    end else if (op.prio) begin
      if (s_out && !s_left) begin
        value_nxt = new_val;
      end else if (s_left && (occ || at_tail)) begin
        value_nxt = left_val;
      end
    end else if (op.deq) begin
      value_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ hw/rtl/cqsi_checker.sv @@
module cqsi_assertions (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_accepted,
  input logic signed [cqsi_pkg::VAL_W-1:0] out_popped_value,
  input logic [cqsi_pkg::CNT_W-1:0]        out_entry_count,
  input logic                              out_is_empty,
  input logic                              out_is_full
);

  // A waiting result must hold back the input side.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input not stalled while result waits");

  // Empty and full cannot both hold.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("empty and full both set");

  // Empty queue reports a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_entry_count == '0)
    else $error("empty queue with nonzero count");

  // A rejected item pops nothing.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_popped_value == '0)
    else $error("rejected item carries a popped value");

  // A stalled result stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_popped_value))
    else $error("stalled result changed");

endmodule

bind circular_queue_with_sorted_insert cqsi_assertions u_cqsi_assertions (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_accepted     (out_accepted),
  .out_popped_value (out_popped_value),
  .out_entry_count  (out_entry_count),
  .out_is_empty     (out_is_empty),
  .out_is_full      (out_is_full)
);
